/* sv/dqu_pkg.sv */
// Shared types and constants for the double-ended queue unit.
// Used by the cell, the top level and the checker; no dependencies.
package dqu_pkg;

    localparam int WORD_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // What a storage cell loads at the next edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_PUSH,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_FROM_HEAD
    } cell_op_t;

    typedef enum logic {
        LS_IDLE,
        LS_LIST
    } list_state_t;

endpackage

/* sv/dqu_cell.sv */
// One storage cell of the deque chain: holds a word and takes it from the
// push port, a neighbor or the front cell. Depends on dqu_pkg.
module dqu_cell (
    input  logic                        clk,
    input  dqu_pkg::cell_op_t           op,
    input  logic [dqu_pkg::WORD_W-1:0]  push_word,
    input  logic [dqu_pkg::WORD_W-1:0]  prev_word,
    input  logic [dqu_pkg::WORD_W-1:0]  next_word,
    input  logic [dqu_pkg::WORD_W-1:0]  head_word,
    output logic [dqu_pkg::WORD_W-1:0]  word
);

    logic [dqu_pkg::WORD_W-1:0] word_reg;
    logic [dqu_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        unique case (op)
            dqu_pkg::CELL_HOLD:      word_next = word_reg;
            dqu_pkg::CELL_LOAD_PUSH: word_next = push_word;
            dqu_pkg::CELL_FROM_PREV: word_next = prev_word;
            dqu_pkg::CELL_FROM_NEXT: word_next = next_word;
            dqu_pkg::CELL_FROM_HEAD: word_next = head_word;
            default:                 word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* sv/double_ended_queue_unit.sv */
// Double-ended queue unit: a chain of DEPTH word cells, front at cell 0.
// Push and pop: one result in the cycle after start; a new command every cycle while busy is low.
// List of n words: n results, one per cycle without gaps, with busy high
// while the chain rotates one cell per cycle back to its original order.
// Reset clears the count and listing state; stored words stay undefined.
// Results cannot be stalled: each is shown for one cycle with result_valid.
module double_ended_queue_unit #(
    parameter int DEPTH = dqu_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dqu_pkg::CMD_W-1:0]     cmd,
    input  logic signed [dqu_pkg::WORD_W-1:0] push_value,
    output logic                          result_valid,
    output logic signed [dqu_pkg::WORD_W-1:0] out_value,
    output logic [dqu_pkg::STATUS_W-1:0]  status,
    output logic                          last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [dqu_pkg::WORD_W-1:0] cell_word [DEPTH];
    dqu_pkg::cell_op_t          cell_op   [DEPTH];

    dqu_pkg::list_state_t state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 valid_reg, valid_next;
    logic [dqu_pkg::WORD_W-1:0] value_reg, value_next;
    dqu_pkg::status_t     status_reg, status_next;
    logic                 last_reg, last_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] back_pos;
    logic [IDX_W-1:0] back_idx;

    assign accept   = start && (state_reg == dqu_pkg::LS_IDLE);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign back_pos = count_reg - CNT_W'(1);
    assign back_idx = back_pos[IDX_W-1:0];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        dqu_cell u_cell (
            .clk       (clk),
            .op        (cell_op[g]),
            .push_word (push_value),
            .prev_word ((g == 0) ? cell_word[g] : cell_word[(g == 0) ? 0 : g - 1]),
            .next_word ((g == DEPTH - 1) ? cell_word[g]
                                         : cell_word[(g == DEPTH - 1) ? g : g + 1]),
            .head_word (cell_word[0]),
            .word      (cell_word[g])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        valid_next  = 1'b0;
        value_next  = '0;
        status_next = dqu_pkg::STAT_OK;
        last_next   = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_op[i] = dqu_pkg::CELL_HOLD;
        end

        unique case (state_reg)
            dqu_pkg::LS_IDLE:
            begin
                if (accept)
                begin
                    case (dqu_pkg::cmd_t'(cmd))
                        dqu_pkg::CMD_PUSH_BACK, dqu_pkg::CMD_PUSH_FRONT:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (full)
                            begin
                                status_next = dqu_pkg::STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (dqu_pkg::cmd_t'(cmd) == dqu_pkg::CMD_PUSH_BACK)
                                    begin
                                        if (CNT_W'(i) == count_reg)
                                            cell_op[i] = dqu_pkg::CELL_LOAD_PUSH;
                                    end
                                    else if (i == 0)
                                        cell_op[i] = dqu_pkg::CELL_LOAD_PUSH;
                                    else
                                        cell_op[i] = dqu_pkg::CELL_FROM_PREV;
                                end
                            end
                        end
                        dqu_pkg::CMD_POP_FRONT:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (empty)
                            begin
                                status_next = dqu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                value_next = cell_word[0];
                                count_next = count_reg - CNT_W'(1);
                                for (int i = 0; i < DEPTH - 1; i++)
                                begin
                                    cell_op[i] = dqu_pkg::CELL_FROM_NEXT;
                                end
                            end
                        end
                        dqu_pkg::CMD_POP_BACK:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (empty)
                            begin
                                status_next = dqu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                value_next = cell_word[back_idx];
                                count_next = back_pos;
                            end
                        end
                        dqu_pkg::CMD_LIST:
                        begin
                            if (empty)
                            begin
                                valid_next  = 1'b1;
                                last_next   = 1'b1;
                                status_next = dqu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = dqu_pkg::LS_LIST;
                                rem_next   = count_reg;
                            end
                        end
                        default:
                        begin
                            // drop unknown commands
                        end
                    endcase
                end
            end
            dqu_pkg::LS_LIST:
            begin
                // emit the front word and rotate it to the rear
                valid_next = 1'b1;
                value_next = cell_word[0];
                last_next  = (rem_reg == CNT_W'(1));
                rem_next   = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                    state_next = dqu_pkg::LS_IDLE;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (CNT_W'(i + 1) < count_reg)
                        cell_op[i] = dqu_pkg::CELL_FROM_NEXT;
                    else if (CNT_W'(i + 1) == count_reg)
                        cell_op[i] = dqu_pkg::CELL_FROM_HEAD;
                end
            end
            default:
            begin
                state_next = dqu_pkg::LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dqu_pkg::LS_IDLE;
            count_reg  <= '0;
            rem_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign busy         = (state_reg == dqu_pkg::LS_LIST);
    assign result_valid = valid_reg;
    assign out_value    = value_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

/* sv/dqu_checker.sv */
// Port-level checks for the double-ended queue unit, bound to the top level.
// Depends on dqu_pkg and double_ended_queue_unit.
module dqu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [dqu_pkg::CMD_W-1:0]         cmd,
    input logic                              result_valid,
    input logic [dqu_pkg::WORD_W-1:0]        out_value,
    input logic [dqu_pkg::STATUS_W-1:0]      status,
    input logic                              last
);

    // a listing runs without gaps until its last word
    a_list_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("listing result stream broke before last");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != dqu_pkg::STAT_OK |-> last && out_value == '0)
        else $error("error result not final or carries data");

    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == dqu_pkg::CMD_PUSH_BACK || cmd == dqu_pkg::CMD_PUSH_FRONT)
        |=> result_valid && last && out_value == '0 && status != dqu_pkg::STAT_EMPTY)
        else $error("push did not give one result");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == dqu_pkg::CMD_POP_FRONT || cmd == dqu_pkg::CMD_POP_BACK)
        |=> result_valid && last && status != dqu_pkg::STAT_FULL)
        else $error("pop did not give one result");

    a_busy_streams: assert property (@(posedge clk) disable iff (!rst_n)
        $past(busy) && busy |-> result_valid && !last)
        else $error("listing word missing while busy");

endmodule

bind double_ended_queue_unit dqu_checker u_dqu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .out_value    (out_value),
    .status       (status),
    .last         (last)
);
